>>> rtl/core/sem_pkg.sv
package sem_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int PIX_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [PIX_W-1:0] MAG_CLAMP = 8'd255;

    // controller -> datapath
    typedef struct packed {
        logic cap;   // latch input beat
        logic rd;    // window / line store / counter update
        logic sq;    // start root extraction
        logic sqrt;  // one root bit
        logic load;  // move result to output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ignore;
        logic emit;
        logic sqrt_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/sem_in_if.sv
interface sem_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel;
    modport source (output valid, cmd, pixel, input ready);
    modport sink   (input valid, cmd, pixel, output ready);
endinterface

>>> rtl/core/sem_out_if.sv
interface sem_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_res;
    logic       frame_last;
    modport source (output valid, edge_res, frame_last, input ready);
    modport sink   (input valid, edge_res, frame_last, output ready);
endinterface

>>> rtl/core/sem_cfg_if.sv
interface sem_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/sem_ctrl.sv
module sem_ctrl
    import sem_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_GRAD = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    if (!i_stat.ignore) n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = i_stat.emit ? S_GRAD : S_IDLE;
            end
            S_GRAD: n_state = S_SQ;
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt = 1'b1;
                if (i_stat.sqrt_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

>>> rtl/core/sem_dp.sv
module sem_dp
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_in,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PIX_W-1:0]      o_edge_res,
    output logic                  o_frame_last,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int CIW = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int ORW = $clog2(MAX_HEIGHT);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);

    logic [FW_W-1:0] r_fw;
    logic [FH_W-1:0] r_fh;
    logic [WCW-1:0]  eff_w;
    logic [HCW-1:0]  eff_h;

    always_comb begin
        if (r_fw == '0)                    eff_w = WCW'(1);
        else if (32'(r_fw) > MAX_WIDTH)    eff_w = WCW'(MAX_WIDTH);
        else                               eff_w = WCW'(r_fw);
        if (r_fh == '0)                    eff_h = HCW'(1);
        else if (32'(r_fh) > MAX_HEIGHT)   eff_h = HCW'(MAX_HEIGHT);
        else                               eff_h = HCW'(r_fh);
    end

    // line stores, registered read at the current input column
    logic [PIX_W-1:0] r_upper [MAX_WIDTH];
    logic [PIX_W-1:0] r_middle[MAX_WIDTH];
    logic [PIX_W-1:0] r_up_q, r_mid_q;

    logic [CIW-1:0] r_in_col, n_in_col;
    logic [RW-1:0]  r_in_row, n_in_row;
    logic [CIW-1:0] r_out_col, n_out_col;
    logic [ORW-1:0] r_out_row, n_out_row;

    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] n_win [3][3];
    logic [PIX_W-1:0] r_view[3][3];
    logic [PIX_W-1:0] n_view[3][3];
    logic [PIX_W-1:0] col[3];

    logic [PIX_W-1:0] r_pix;
    logic             emit, last, r_last;
    logic [31:0]      col_inc, row_inc, ocol_inc;

    always_comb begin
        col[0] = (32'(r_in_row) >= 2) ? r_up_q : '0;
        col[1] = (32'(r_in_row) >= 1) ? r_mid_q : '0;
        col[2] = (32'(r_in_row) >= 32'(eff_h)) ? '0 : r_pix;
        for (int r = 0; r < 3; r++) begin
            if (r_in_col == '0) begin
                n_view[r][0] = r_win[r][1];
                n_view[r][1] = r_win[r][2];
                n_view[r][2] = '0;
                n_win[r][0]  = '0;
                n_win[r][1]  = '0;
                n_win[r][2]  = col[r];
            end else begin
                n_win[r][0]  = r_win[r][1];
                n_win[r][1]  = r_win[r][2];
                n_win[r][2]  = col[r];
                n_view[r][0] = r_win[r][1];
                n_view[r][1] = r_win[r][2];
                n_view[r][2] = col[r];
            end
        end
        emit = (r_in_col == '0) ? (32'(r_in_row) >= 2) : (32'(r_in_row) >= 1);
        last = emit && (32'(r_out_row) == 32'(eff_h) - 1)
                    && (32'(r_out_col) == 32'(eff_w) - 1);

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        ocol_inc  = 32'(r_out_col) + 1;
        if (emit) begin
            if (ocol_inc >= 32'(eff_w)) begin
                n_out_col = '0;
                n_out_row = ORW'(32'(r_out_row) + 1);
            end else begin
                n_out_col = CIW'(ocol_inc);
            end
        end
        col_inc  = 32'(r_in_col) + 1;
        row_inc  = 32'(r_in_row);
        n_in_col = CIW'(col_inc);
        if (col_inc >= 32'(eff_w)) begin
            n_in_col = '0;
            row_inc  = 32'(r_in_row) + 1;
        end
        n_in_row = RW'(row_inc);
    end

    always_ff @(posedge i_clk) begin
        r_up_q  <= r_upper[r_in_col];
        r_mid_q <= r_middle[r_in_col];
        if (i_cmd.rd) begin
            r_upper[r_in_col]  <= col[1];
            r_middle[r_in_col] <= col[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pix <= i_pixel;
        end
        if (i_cmd.rd) begin
            r_view <= n_view;
            r_last <= last;
        end
    end

    // frame size registers, position counters and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= FW_RESET;
            r_fh      <= FH_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_win     <= '{default: '{default: '0}};
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FRAME_WIDTH || i_cfg_idx == REG_FRAME_HEIGHT) begin
                if (i_cfg_idx == REG_FRAME_WIDTH) r_fw <= i_cfg_data[FW_W-1:0];
                else                              r_fh <= i_cfg_data[FH_W-1:0];
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_win     <= '{default: '{default: '0}};
            end
        end else if (i_cmd.rd) begin
            if (last || row_inc > 32'(eff_h) + 1) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_win     <= '{default: '{default: '0}};
            end else begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
                r_win     <= n_win;
            end
        end
    end

    // gradient and sum of squares, free running behind r_view
    logic signed [11:0] r_gx, r_gy;
    logic        [21:0] r_sum;
    logic signed [21:0] gx_sq, gy_sq;

    always_ff @(posedge i_clk) begin
        r_gx <= (12'(r_view[0][2]) + (12'(r_view[1][2]) << 1) + 12'(r_view[2][2]))
              - (12'(r_view[0][0]) + (12'(r_view[1][0]) << 1) + 12'(r_view[2][0]));
        r_gy <= (12'(r_view[0][0]) + (12'(r_view[0][1]) << 1) + 12'(r_view[0][2]))
              - (12'(r_view[2][0]) + (12'(r_view[2][1]) << 1) + 12'(r_view[2][2]));
        r_sum <= 22'(gx_sq) + 22'(gy_sq);
    end

    assign gx_sq = 22'(r_gx) * 22'(r_gx);
    assign gy_sq = 22'(r_gy) * 22'(r_gy);

    // restoring root, one bit a cycle from the top
    logic [PIX_W-1:0] r_root, trial;
    logic [2:0]       r_bit;
    logic [15:0]      trial_sq;

    assign trial    = r_root | (PIX_W'(1) << r_bit);
    assign trial_sq = 16'(trial) * 16'(trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_root <= '0;
            r_bit  <= 3'd7;
        end else if (i_cmd.sqrt) begin
            if (trial_sq <= r_sum[15:0]) r_root <= trial;
            r_bit <= r_bit - 3'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // r_sum holds steady until the next window update, so the clamp reads it here
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_edge_res   <= (r_sum[21:16] != '0) ? MAG_CLAMP : r_root;
            o_frame_last <= r_last;
        end
    end

    assign o_stat.ignore    = (i_cmd_in == CMD_FLUSH) && (32'(r_in_row) < 32'(eff_h));
    assign o_stat.emit      = emit;
    assign o_stat.sqrt_done = (r_bit == 3'd0);
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_in_col) < 32'(eff_w))
        else $error("input column past frame width");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_in_row) <= 32'(eff_h) + 1)
        else $error("input row past flush rows");
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd && last && !i_cfg_we) |=> (r_in_row == '0 && r_out_row == '0))
        else $error("counters not cleared after frame end");

endmodule

>>> rtl/core/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude, one beat in flight at a time.
// Flow: once an input beat is accepted, the result is registered through the
// read, gradient, squares, 8 root steps one bit a cycle, and output load.
// A new beat is taken only when the last is through: after the output load for a
// beat with a result (held while the output is full), after the read otherwise.
// Reset (i_rst_n low, synchronous): counters, window, sizes (640x480), valids.
module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sem_in_if.sink    i_pix,
    sem_out_if.source o_res,
    sem_cfg_if.sink   i_cfg
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // config beats are taken at any time; the host must write only while idle, which the block does not enforce
    assign i_cfg.ready = 1'b1;

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: line stores, window, counters, gradient, root, output reg
    sem_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_in     (i_pix.cmd),
        .i_pixel      (i_pix.pixel),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_edge_res   (o_res.edge_res),
        .o_frame_last (o_res.frame_last),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );

endmodule
